FILE: src/lcg_pkg.sv
// Package for the LCG sequence generator: field widths, register indexes,
// register reset values and status codes. No dependencies.
`default_nettype none

package lcg_pkg;

  localparam int unsigned WORD_W   = 31;  // seed, state and register width
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PROD_W   = 2 * WORD_W;  // exact a*x + c fits here
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_LENGTH = 64;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MULTIPLIER = 2'd0;
  localparam cfg_idx_t REG_INCREMENT  = 2'd1;
  localparam cfg_idx_t REG_MODULUS    = 2'd2;

  localparam word_t MULTIPLIER_RST = 31'd1103515245;
  localparam word_t INCREMENT_RST  = 31'd12345;
  localparam word_t MODULUS_RST    = 31'd2147483647;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_ZERO_MOD = 2'd1;
  localparam status_t STATUS_BAD_LEN  = 2'd2;

endpackage

`default_nettype wire

FILE: src/lcg_if.sv
// Valid/ready channel interfaces for request beats and result beats.
// Depends on lcg_pkg.
`default_nettype none

interface lcg_req_if
  import lcg_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t seed;
  len_t  length;

  modport source (output valid, output seed, output length, input ready);
  modport sink   (input valid, input seed, input length, output ready);
endinterface

interface lcg_res_if
  import lcg_pkg::*;
  ();
  logic    valid;
  logic    ready;
  byte_t   value_byte;
  logic    last;
  status_t status;
  word_t   next_seed;

  modport source (output valid, output value_byte, output last, output status,
                  output next_seed, input ready);
  modport sink   (input valid, input value_byte, input last, input status,
                  input next_seed, output ready);
endinterface

`default_nettype wire

FILE: src/lcg_sequence_generator_top.sv
// LCG sequence generator top level: bit-serial multiply and modular reduce.
// Depends on lcg_pkg and the channel interfaces in lcg_if.sv.
//
// One request (seed, length) yields length result beats, each the low byte of
// the state before a step x = (a*x + c) mod m; the last beat carries the full
// next state as next_seed. A zero modulus or a length of 0 or above 64 gives
// a single error beat. Each value passes through a shift-add multiply (one
// multiplier bit per cycle), the increment add, a restoring reduction (one
// product bit per cycle) and a hand-off of the beat to the output register,
// which waits out any output stall. A new request is taken once the last beat
// of the previous one sits in the output register.
`default_nettype none

module lcg_sequence_generator_top
  import lcg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  lcg_req_if.sink       in_ch,
  lcg_res_if.source     out_ch,
  input  wire logic     cfg_we,
  input  wire cfg_idx_t cfg_idx,
  input  wire word_t    cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;
  localparam logic [2:0] ST_ERR  = 3'd5;

  localparam int unsigned CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(WORD_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  word_t      mult_r, inc_r, mod_r;
  logic [2:0] state_r;
  logic [CNT_W-1:0] cnt_r;
  prod_t      t_r;
  word_t      x_r;
  word_t      rem_r;
  len_t       left_r;
  status_t    err_r;

  logic    out_valid_r;
  byte_t   out_byte_r;
  logic    out_last_r;
  status_t out_status_r;
  word_t   out_seed_r;

  logic                  slot_free;
  logic                  load_out;
  logic [WORD_W:0]       mul_sum;
  logic [WORD_W:0]       div_tmp;
  logic [WORD_W:0]       div_diff;
  logic                  div_ge;
  logic                  push_last;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign load_out    = slot_free && (state_r == ST_PUSH || state_r == ST_ERR);

  // add multiplicand when the low product bit is set, then shift right
  assign mul_sum  = {1'b0, t_r[PROD_W-1:WORD_W]} + (t_r[0] ? {1'b0, mult_r} : '0);
  // bring in the next product bit and subtract the modulus if it fits
  assign div_tmp  = {rem_r, t_r[PROD_W-1]};
  assign div_ge   = (div_tmp >= {1'b0, mod_r});
  assign div_diff = div_tmp - {1'b0, mod_r};
  assign push_last = (left_r == len_t'(1));

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value_byte = out_byte_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.next_seed  = out_seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= MULTIPLIER_RST;
      inc_r  <= INCREMENT_RST;
      mod_r  <= MODULUS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MULTIPLIER: mult_r <= cfg_wdata;
        REG_INCREMENT:  inc_r  <= cfg_wdata;
        REG_MODULUS:    mod_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // drop the beat once taken, unless a new one loads this cycle
      if (out_ch.ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            x_r    <= in_ch.seed;
            left_r <= in_ch.length;
            t_r    <= {WORD_W'(0), in_ch.seed};
            cnt_r  <= '0;
            if (mod_r == '0) begin
              err_r   <= STATUS_ZERO_MOD;
              state_r <= ST_ERR;
            end else if (in_ch.length == '0 || in_ch.length > len_t'(MAX_LENGTH)) begin
              err_r   <= STATUS_BAD_LEN;
              state_r <= ST_ERR;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          t_r <= {mul_sum, t_r[WORD_W-1:1]};
          if (cnt_r == MUL_LAST) begin
            state_r <= ST_ADD;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_ADD: begin
          t_r     <= t_r + {WORD_W'(0), inc_r};
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= div_ge ? div_diff[WORD_W-1:0] : div_tmp[WORD_W-1:0];
          t_r   <= {t_r[PROD_W-2:0], 1'b0};
          if (cnt_r == DIV_LAST) begin
            state_r <= ST_PUSH;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_PUSH: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_byte_r   <= x_r[BYTE_W-1:0];
            out_last_r   <= push_last;
            out_status_r <= STATUS_OK;
            out_seed_r   <= push_last ? rem_r : '0;
            x_r          <= rem_r;
            left_r       <= left_r - len_t'(1);
            t_r          <= {WORD_W'(0), rem_r};
            cnt_r        <= '0;
            state_r      <= push_last ? ST_IDLE : ST_MUL;
          end
        end
        ST_ERR: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_byte_r   <= '0;
            out_last_r   <= 1'b1;
            out_status_r <= err_r;
            out_seed_r   <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for lcg_sequence_generator_top: directed table, then random phases.
// Depends on lcg_pkg and the channel interfaces in src/lcg_if.sv.
`timescale 1ns / 100ps

module testbench;
  import lcg_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 17;
  localparam int MAX_REPORTS = 20;
  localparam word_t WORD_MAX = 31'h7FFFFFFF;
  localparam cfg_idx_t REG_NONE = 2'd3;  // no register here, write is dropped

  typedef struct packed {
    byte_t   value_byte;
    logic    last;
    status_t status;
    word_t   next_seed;
  } lcg_beat_t;

  typedef enum logic [1:0] {ROW_CONFIG, ROW_REQUEST, ROW_REQUEST_TYPED} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cfg_idx_t  idx;
    word_t     word;
    len_t      length;
    lcg_beat_t typed_beat;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  word_t    cfg_wdata;

  lcg_req_if req_ch ();
  lcg_res_if res_ch ();

  lcg_sequence_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  word_t     lcg_mult;
  word_t     lcg_incr;
  word_t     lcg_mod;
  lcg_beat_t expected_beats[$];
  stim_row_t stim_rows[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  bit        long_hold_req = 1'b0;

  always #2 clk = ~clk;

  // Expected beats for one request under the current register copy.
  function automatic void queue_sequence(input word_t seed, input len_t len);
    word_t       x;
    word_t       nx;
    logic [63:0] t;
    int          k;
    if (lcg_mod == '0) begin
      expected_beats.push_back('{8'd0, 1'b1, STATUS_ZERO_MOD, word_t'(0)});
    end else if (len == '0 || int'(len) > int'(MAX_LENGTH)) begin
      expected_beats.push_back('{8'd0, 1'b1, STATUS_BAD_LEN, word_t'(0)});
    end else begin
      x = seed;
      for (k = 0; k < int'(len); k++) begin
        t = 64'(lcg_mult) * 64'(x) + 64'(lcg_incr);
        nx = word_t'(t % 64'(lcg_mod));
        if (k == int'(len) - 1) begin
          expected_beats.push_back('{x[7:0], 1'b1, STATUS_OK, nx});
        end else begin
          expected_beats.push_back('{x[7:0], 1'b0, STATUS_OK, word_t'(0)});
        end
        x = nx;
      end
    end
  endfunction

  function automatic void add_request(input word_t seed, input len_t len);
    stim_row_t row;
    row.kind = ROW_REQUEST;
    row.idx = REG_NONE;
    row.word = seed;
    row.length = len;
    row.typed_beat = '0;
    stim_rows.push_back(row);
  endfunction

  // Single-beat outcome that is obvious by inspection; next_seed is zero in every such case.
  function automatic void add_typed(input word_t seed, input len_t len, input byte_t vb,
                                    input status_t st);
    stim_row_t row;
    row.kind = ROW_REQUEST_TYPED;
    row.idx = REG_NONE;
    row.word = seed;
    row.length = len;
    row.typed_beat = '{vb, 1'b1, st, word_t'(0)};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_config(input cfg_idx_t idx, input word_t data);
    stim_row_t row;
    row.kind = ROW_CONFIG;
    row.idx = idx;
    row.word = data;
    row.length = '0;
    row.typed_beat = '0;
    stim_rows.push_back(row);
  endfunction

  task automatic offer_request(input word_t seed, input len_t len, input bit typed,
                               input lcg_beat_t typed_beat);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid  <= 1'b1;
    req_ch.seed   <= seed;
    req_ch.length <= len;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    burst_left--;
    if (typed) begin
      expected_beats.push_back(typed_beat);
    end else begin
      queue_sequence(seed, len);
    end
  endtask

  // Drop valid and wait until every expected beat has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_we high so that writes can go back to back; the caller lowers it.
  task automatic write_reg(input cfg_idx_t idx, input word_t data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_MULTIPLIER: lcg_mult = data;
      REG_INCREMENT:  lcg_incr = data;
      REG_MODULUS:    lcg_mod = data;
      default: ;
    endcase
  endtask

  initial begin
    int    i;
    int    phase;
    int    pick;
    word_t seed;
    len_t  len;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_MULTIPLIER;
    cfg_wdata     <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.seed   <= '0;
    req_ch.length <= '0;
    lcg_mult = MULTIPLIER_RST;
    lcg_incr = INCREMENT_RST;
    lcg_mod  = MODULUS_RST;

    // Reset values; the max seed equals the modulus here.
    add_request(31'd0, 7'd1);
    add_request(WORD_MAX, 7'd1);
    add_request(31'd12345, 7'd64);
    add_typed(31'd1, 7'd0, 8'd0, STATUS_BAD_LEN);
    add_typed(31'd2, 7'd65, 8'd0, STATUS_BAD_LEN);
    add_typed(WORD_MAX, 7'd127, 8'd0, STATUS_BAD_LEN);
    add_request(31'h2AAAAAAA, 7'd5);
    add_request(31'h55555555, 7'd3);
    // Modulus of one: every next state is zero.
    add_config(REG_MODULUS, 31'd1);
    add_typed(WORD_MAX, 7'd1, 8'hFF, STATUS_OK);
    add_typed(31'h123456AB, 7'd1, 8'hAB, STATUS_OK);
    // Zero modulus wins over a bad length.
    add_config(REG_MODULUS, 31'd0);
    add_typed(31'd7, 7'd3, 8'd0, STATUS_ZERO_MOD);
    add_typed(31'd7, 7'd0, 8'd0, STATUS_ZERO_MOD);
    add_typed(31'd7, 7'd100, 8'd0, STATUS_ZERO_MOD);
    // Multiplier and increment above the modulus.
    add_config(REG_MULTIPLIER, WORD_MAX);
    add_config(REG_INCREMENT, WORD_MAX);
    add_config(REG_MODULUS, 31'd1000);
    add_request(31'd999, 7'd8);
    add_request(WORD_MAX, 7'd4);
    add_config(REG_MULTIPLIER, 31'd0);
    add_config(REG_INCREMENT, 31'd0);
    add_config(REG_MODULUS, WORD_MAX);
    add_request(31'd77, 7'd3);
    // Out-of-range index must leave the registers alone.
    add_config(REG_NONE, 31'd5);
    add_request(31'd5, 7'd2);
    add_config(REG_MULTIPLIER, 31'd48271);
    add_request(31'd1, 7'd10);
    add_config(REG_MODULUS, 31'd2);
    add_request(31'd3, 7'd6);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < stim_rows.size(); i++) begin
      if (stim_rows[i].kind == ROW_CONFIG) begin
        if (i > 0 && stim_rows[i-1].kind != ROW_CONFIG) drain();
        write_reg(stim_rows[i].idx, stim_rows[i].word);
        if (i + 1 == stim_rows.size() || stim_rows[i+1].kind != ROW_CONFIG) cfg_we <= 1'b0;
      end else begin
        offer_request(stim_rows[i].word, stim_rows[i].length,
                      stim_rows[i].kind == ROW_REQUEST_TYPED, stim_rows[i].typed_beat);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      pick = (phase == 0) ? 0 : $urandom_range(0, 5);
      case (pick)
        0: begin
          write_reg(REG_MULTIPLIER, MULTIPLIER_RST);
          write_reg(REG_INCREMENT, INCREMENT_RST);
          write_reg(REG_MODULUS, MODULUS_RST);
        end
        1: begin
          write_reg(REG_MULTIPLIER, 31'd48271);
          write_reg(REG_INCREMENT, 31'd0);
          write_reg(REG_MODULUS, WORD_MAX);
        end
        2: begin
          write_reg(REG_MULTIPLIER, word_t'($urandom));
          write_reg(REG_INCREMENT, word_t'($urandom));
          write_reg(REG_MODULUS, word_t'($urandom));
        end
        3: begin
          write_reg(REG_MULTIPLIER, word_t'($urandom));
          write_reg(REG_INCREMENT, word_t'($urandom));
          write_reg(REG_MODULUS, word_t'($urandom_range(1, 1000)));
        end
        4: begin
          write_reg(REG_MULTIPLIER, word_t'($urandom));
          write_reg(REG_MODULUS, 31'd0);
        end
        default: begin
          write_reg(REG_MULTIPLIER, WORD_MAX);
          write_reg(REG_INCREMENT, WORD_MAX);
          write_reg(REG_MODULUS, WORD_MAX);
        end
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, word_t'($urandom));
      cfg_we <= 1'b0;
      if (phase == 2) long_hold_req = 1'b1;

      repeat (PHASE_ITEMS) begin
        seed = word_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) len = len_t'($urandom_range(1, 8));
        else if (pick < 85) len = len_t'($urandom_range(9, 63));
        else if (pick < 90) len = len_t'(MAX_LENGTH);
        else len = ($urandom_range(0, 1) == 0) ? len_t'(0) : len_t'($urandom_range(65, 127));
        offer_request(seed, len, 1'b0, '0);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("** lcg_sequence_generator_top: PASSED **");
    end else begin
      $display("** lcg_sequence_generator_top: FAILED **");
    end
    $finish;
  end

  // Result sink: random and patterned stalls, plus one long hold-off on request.
  initial begin
    int mode;
    int span;
    int k;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (long_hold_req) begin
        res_ch.ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 250);
        for (k = 0; k < span; k++) begin
          case (mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 3) != 0);
            2: res_ch.ready <= (k % 7 < 4);
            default: res_ch.ready <= ($urandom_range(0, 1) == 1);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    lcg_beat_t got;
    lcg_beat_t want;
    if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = '{res_ch.value_byte, res_ch.last, res_ch.status, res_ch.next_seed};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result beat: byte %0h last %0b status %0d next_seed %0h",
                   $realtime, got.value_byte, got.last, got.status, got.next_seed);
      end else begin
        want = expected_beats.pop_front();
        if (got.value_byte !== want.value_byte || got.last !== want.last ||
            got.status !== want.status || got.next_seed !== want.next_seed) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: beat mismatch: expected byte %0h last %0b status %0d next_seed %0h, %s",
                     $realtime, want.value_byte, want.last, want.status, want.next_seed,
                     $sformatf("got byte %0h last %0b status %0d next_seed %0h",
                               got.value_byte, got.last, got.status, got.next_seed));
        end
      end
    end
  end

  // End the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $realtime, STALL_LIMIT);
      $display("** lcg_sequence_generator_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
src/lcg_pkg.sv
src/lcg_if.sv
src/lcg_sequence_generator_top.sv
tb/testbench.sv
